[hdl/ghash_pkg.sv]
// ----------------------------------------------------------------------------
// ghash_pkg
// shared widths, register indexes and the gf(2^128) multiply-by-x helper
// ----------------------------------------------------------------------------
package ghash_pkg;

  localparam int BlockW   = 128;
  localparam int HalfW    = 64;
  localparam int CfgIdxW  = 8;

  // reflected reduction constant for x^128 + x^7 + x^2 + x + 1
  localparam logic [BlockW-1:0] ReducePoly = {8'he1, {(BlockW-8){1'b0}}};

  typedef enum logic [CfgIdxW-1:0] {
    REG_SUBKEY_HIGH = 8'd0,
    REG_SUBKEY_LOW  = 8'd1
  } cfg_reg_e;

  // multiply by x in the reflected bit order
  function automatic logic [BlockW-1:0] gf_times_x(logic [BlockW-1:0] v);
    logic [BlockW-1:0] r;
    r = v >> 1;
    if (v[0]) begin
      r = r ^ ReducePoly;
    end
    return r;
  endfunction

endpackage

[hdl/ghash_mul_step.sv]
// ----------------------------------------------------------------------------
// ghash_mul_step
// one digit step of the gf(2^128) multiply: z * x^digit_bits plus digit * H
// ----------------------------------------------------------------------------
module ghash_mul_step
  import ghash_pkg::*;
#(
  parameter int DIGIT_BITS = 4
) (
  input  logic [BlockW-1:0]     z_i,
  input  logic [DIGIT_BITS-1:0] digit_i,
  input  logic [BlockW-1:0]     subkey_i,
  output logic [BlockW-1:0]     z_o
);

  logic [BlockW-1:0] pow [DIGIT_BITS];
  logic [BlockW-1:0] mult;
  logic [BlockW-1:0] zs;

  // digit multiple built from the powers H * x^i
  always_comb begin
    pow[0] = subkey_i;
    for (int i = 1; i < DIGIT_BITS; i++) begin
      pow[i] = gf_times_x(pow[i-1]);
    end
    mult = '0;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      if (digit_i[j]) begin
        mult = mult ^ pow[DIGIT_BITS-1-j];
      end
    end
  end

  always_comb begin
    zs = z_i;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      zs = gf_times_x(zs);
    end
    z_o = zs ^ mult;
  end

endmodule

[hdl/ghash_accumulator.sv]
// ----------------------------------------------------------------------------
// ghash_accumulator
// an absorb transfer runs ceil(128/DIGIT_BITS) digit steps (32 at the
// default) through one shared step unit; the result is registered after the
// last step, or held in ST_DONE while the output is full; no new transfer is
// taken until then, as the accumulator feeds back through the step unit
// reset: asynchronous active low, clears accumulator, subkey and handshake state
// ----------------------------------------------------------------------------
module ghash_accumulator
  import ghash_pkg::*;
#(
  parameter int DIGIT_BITS = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [HalfW-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [BlockW-1:0]    s_axis_tdata,   // block_low, block_high
  input  logic                 s_axis_tuser,   // kind
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [BlockW-1:0]    m_axis_tdata    // hash_low, hash_high
);

  localparam int DigitCount = (BlockW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int WordW      = DigitCount * DIGIT_BITS;
  localparam int PadW       = WordW - BlockW;
  localparam int CntW       = $clog2(DigitCount);
  localparam logic [CntW-1:0] LastCnt = CntW'(DigitCount - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [WordW-1:0]  opnd_q, opnd_d;
  logic [BlockW-1:0] acc_q, acc_d;
  logic [BlockW-1:0] subkey_q;
  logic              out_valid_q, out_valid_d;
  logic [BlockW-1:0] out_data_q, out_data_d;
  logic [BlockW-1:0] step_z;
  logic [BlockW-1:0] blk_sum;
  logic              s_xfer, out_free, last_step;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign last_step     = (cnt_q == LastCnt);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_data_q[HalfW-1:0], out_data_q[BlockW-1:HalfW]};

  // accumulator keeps hash_high in the upper half
  assign blk_sum = acc_q ^ {s_axis_tdata[HalfW-1:0], s_axis_tdata[BlockW-1:HalfW]};

  ghash_mul_step #(
    .DIGIT_BITS(DIGIT_BITS)
  ) u_step (
    .z_i      (acc_q),
    .digit_i  (opnd_q[DIGIT_BITS-1:0]),
    .subkey_i (subkey_q),
    .z_o      (step_z)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    opnd_d      = opnd_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_xfer) begin
          if (s_axis_tuser) begin
            acc_d = '0;
            if (out_free) begin
              out_valid_d = 1'b1;
              out_data_d  = '0;
            end else begin
              state_d = ST_DONE;
            end
          end else begin
            acc_d   = '0;
            opnd_d  = WordW'(blk_sum) << PadW;
            cnt_d   = '0;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        acc_d  = step_z;
        opnd_d = opnd_q >> DIGIT_BITS;
        cnt_d  = cnt_q + CntW'(1);
        if (last_step) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = step_z;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q     <= opnd_d;
    out_data_q <= out_data_d;
  end

  // subkey register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subkey_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SUBKEY_HIGH: subkey_q[BlockW-1:HalfW] <= cfg_data_i;
        REG_SUBKEY_LOW:  subkey_q[HalfW-1:0]      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_absorb_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && !s_axis_tuser) |=> (state_q == ST_RUN && cnt_q == '0))
    else $error("absorb transfer did not start the digit sequence");

  a_clear_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && s_axis_tuser && out_free) |=> (m_axis_tvalid && m_axis_tdata == '0))
    else $error("clear transfer did not return a zero hash");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      ($past(state_q == ST_RUN && last_step) || $past(state_q == ST_DONE) ||
       $past(s_xfer && s_axis_tuser)))
    else $error("result appeared without a finished item");
`endif

endmodule
